// ----- design/scrl_pkg.sv -----
// Shared types and constants for the screen region locator.
package scrl_pkg;

    localparam int MAX_SCREENS_DEF = 8;
    localparam int ENTRY_W = 64;
    localparam int COORD_W = 16;
    localparam int EDGE_W = 18;
    localparam int AREA_W = 32;
    localparam int COUNT_W = 4;
    localparam int SEL_W = 3;
    localparam int ENTRY_IDX_W = 3;
    localparam int IN_DATA_W = 72;
    localparam int OUT_DATA_W = 104;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_RECT  = 2'd1,
        REQ_POINT = 2'd2,
        REQ_BBOX  = 2'd3
    } req_e;

    // One evaluated table entry, leaving the product stage.
    typedef struct packed {
        logic                      valid;
        logic                      last;
        logic                      first;
        logic                      hit;
        logic [AREA_W-1:0]         area;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [EDGE_W-1:0]  r;
        logic signed [EDGE_W-1:0]  b;
    } scan_t;

endpackage

// ----- design/scrl_mem.sv -----
// Screen table storage: one write port, one registered read port.
module scrl_mem
    import scrl_pkg::*;
#(
    parameter int DEPTH = MAX_SCREENS_DEF,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic               clk,
    input  logic               we,
    input  logic [AW-1:0]      waddr,
    input  logic [ENTRY_W-1:0] wdata,
    input  logic               re,
    input  logic [AW-1:0]      raddr,
    output logic [ENTRY_W-1:0] rdata
);

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/scrl_eval.sv -----
// Per-entry evaluation: overlap lengths, point test, edges, then overlap product.
module scrl_eval
    import scrl_pkg::*;
#(
    parameter int AW = 3
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      issue,
    input  logic                      issue_last,
    input  logic [AW-1:0]             issue_idx,
    input  logic [ENTRY_W-1:0]        rdata,
    input  logic signed [COORD_W-1:0] q_x,
    input  logic signed [COORD_W-1:0] q_y,
    input  logic [COORD_W-1:0]        q_w,
    input  logic [COORD_W-1:0]        q_h,
    output scan_t                     scan,
    output logic [AW-1:0]             scan_idx
);

    // Tags aligned with the memory read data
    logic          t_valid_reg;
    logic          t_last_reg;
    logic [AW-1:0] t_idx_reg;

    // First stage
    logic                      s1_valid_reg;
    logic                      s1_last_reg;
    logic                      s1_first_reg;
    logic                      s1_hit_reg;
    logic [AW-1:0]             s1_idx_reg;
    logic [COORD_W-1:0]        s1_ovx_reg;
    logic [COORD_W-1:0]        s1_ovy_reg;
    logic signed [COORD_W-1:0] s1_x_reg;
    logic signed [COORD_W-1:0] s1_y_reg;
    logic signed [EDGE_W-1:0]  s1_r_reg;
    logic signed [EDGE_W-1:0]  s1_b_reg;

    scan_t         s2_reg;
    logic [AW-1:0] s2_idx_reg;

    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic signed [EDGE_W-1:0]  sx_e;
    logic signed [EDGE_W-1:0]  sy_e;
    logic signed [EDGE_W-1:0]  sr;
    logic signed [EDGE_W-1:0]  sb;
    logic signed [EDGE_W-1:0]  qx_e;
    logic signed [EDGE_W-1:0]  qy_e;
    logic signed [EDGE_W-1:0]  qr;
    logic signed [EDGE_W-1:0]  qb;
    logic signed [EDGE_W-1:0]  hi_x;
    logic signed [EDGE_W-1:0]  lo_x;
    logic signed [EDGE_W-1:0]  hi_y;
    logic signed [EDGE_W-1:0]  lo_y;
    logic signed [EDGE_W-1:0]  dx;
    logic signed [EDGE_W-1:0]  dy;
    logic [COORD_W-1:0]        ovx;
    logic [COORD_W-1:0]        ovy;
    logic                      hit;

    always_comb
    begin
        sx   = rdata[COORD_W-1:0];
        sy   = rdata[2*COORD_W-1:COORD_W];
        sx_e = EDGE_W'(sx);
        sy_e = EDGE_W'(sy);
        sr   = sx_e + $signed({2'b00, rdata[3*COORD_W-1:2*COORD_W]});
        sb   = sy_e + $signed({2'b00, rdata[4*COORD_W-1:3*COORD_W]});
        qx_e = EDGE_W'(q_x);
        qy_e = EDGE_W'(q_y);
        qr   = qx_e + $signed({2'b00, q_w});
        qb   = qy_e + $signed({2'b00, q_h});

        hi_x = (sr < qr) ? sr : qr;
        lo_x = (sx_e > qx_e) ? sx_e : qx_e;
        hi_y = (sb < qb) ? sb : qb;
        lo_y = (sy_e > qy_e) ? sy_e : qy_e;
        dx   = hi_x - lo_x;
        dy   = hi_y - lo_y;
        // overlap never exceeds the shorter length, so 16 bits hold it
        ovx  = (sx_e < qr && sr > qx_e) ? dx[COORD_W-1:0] : '0;
        ovy  = (sy_e < qb && sb > qy_e) ? dy[COORD_W-1:0] : '0;

        // left and top edges inclusive, right and bottom exclusive
        hit  = (qx_e >= sx_e) && (qy_e >= sy_e) && (qx_e < sr) && (qy_e < sb);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_valid_reg  <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_reg       <= '0;
        end
        else
        begin
            t_valid_reg  <= issue;
            s1_valid_reg <= t_valid_reg;
            s2_reg.valid <= s1_valid_reg;
            s2_reg.last  <= s1_last_reg;
            s2_reg.first <= s1_first_reg;
            s2_reg.hit   <= s1_hit_reg;
            s2_reg.area  <= AREA_W'(s1_ovx_reg) * AREA_W'(s1_ovy_reg);
            s2_reg.x     <= s1_x_reg;
            s2_reg.y     <= s1_y_reg;
            s2_reg.r     <= s1_r_reg;
            s2_reg.b     <= s1_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t_last_reg   <= issue_last;
        t_idx_reg    <= issue_idx;

        s1_last_reg  <= t_last_reg;
        s1_first_reg <= (t_idx_reg == '0);
        s1_idx_reg   <= t_idx_reg;
        s1_hit_reg   <= hit;
        s1_ovx_reg   <= ovx;
        s1_ovy_reg   <= ovy;
        s1_x_reg     <= sx;
        s1_y_reg     <= sy;
        s1_r_reg     <= sr;
        s1_b_reg     <= sb;

        s2_idx_reg   <= s1_idx_reg;
    end

    assign scan     = s2_reg;
    assign scan_idx = s2_idx_reg;

endmodule

// ----- design/scrl_accum.sv -----
// Running best area, first point hit and bounding edges over one table scan.
module scrl_accum
    import scrl_pkg::*;
#(
    parameter int AW = 3
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      clear,
    input  scan_t                     scan,
    input  logic [AW-1:0]             scan_idx,
    output logic [AW-1:0]             best_idx,
    output logic [AREA_W-1:0]         best_area,
    output logic                      found,
    output logic [AW-1:0]             hit_idx,
    output logic signed [COORD_W-1:0] left_edge,
    output logic signed [EDGE_W-1:0]  right_edge,
    output logic signed [COORD_W-1:0] top_edge,
    output logic signed [EDGE_W-1:0]  bottom_edge
);

    logic [AW-1:0]             best_idx_reg;
    logic [AREA_W-1:0]         best_area_reg;
    logic                      found_reg;
    logic [AW-1:0]             hit_idx_reg;
    logic signed [COORD_W-1:0] left_reg;
    logic signed [EDGE_W-1:0]  right_reg;
    logic signed [COORD_W-1:0] top_reg;
    logic signed [EDGE_W-1:0]  bottom_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_idx_reg  <= '0;
            best_area_reg <= '0;
            found_reg     <= 1'b0;
            hit_idx_reg   <= '0;
            left_reg      <= '0;
            right_reg     <= '0;
            top_reg       <= '0;
            bottom_reg    <= '0;
        end
        else if (clear)
        begin
            best_idx_reg  <= '0;
            best_area_reg <= '0;
            found_reg     <= 1'b0;
            hit_idx_reg   <= '0;
            left_reg      <= '0;
            right_reg     <= '0;
            top_reg       <= '0;
            bottom_reg    <= '0;
        end
        else if (scan.valid)
        begin
            // strict compare keeps the earlier screen on a tie
            if (scan.area > best_area_reg)
            begin
                best_area_reg <= scan.area;
                best_idx_reg  <= scan_idx;
            end
            if (scan.hit && !found_reg)
            begin
                found_reg   <= 1'b1;
                hit_idx_reg <= scan_idx;
            end
            if (scan.first || scan.x < left_reg)
            begin
                left_reg <= scan.x;
            end
            if (scan.first || scan.y < top_reg)
            begin
                top_reg <= scan.y;
            end
            if (scan.first || scan.r > right_reg)
            begin
                right_reg <= scan.r;
            end
            if (scan.first || scan.b > bottom_reg)
            begin
                bottom_reg <= scan.b;
            end
        end
    end

    assign best_idx    = best_idx_reg;
    assign best_area   = best_area_reg;
    assign found       = found_reg;
    assign hit_idx     = hit_idx_reg;
    assign left_edge   = left_reg;
    assign right_edge  = right_reg;
    assign top_edge    = top_reg;
    assign bottom_edge = bottom_reg;

endmodule

// ----- design/screen_region_locator.sv -----
// Top level of the screen region locator: request sequencer and result register.
//
// Requests arrive on the s_axis channel, one transfer per request; the kind of
// request rides on s_axis_tuser. Every request yields exactly one result transfer
// on the m_axis channel. cfg_we/cfg_wdata set the number of screens in use.
//
// A table write lands in the screen memory at the accepting edge and its
// (all zero) result is loaded into the output register from the finish state.
// A query reads the table one entry per cycle through the single memory read
// port, scanning the screens in use (at most 8 for the default eight-entry
// table). The next request is taken in the cycle after the result is loaded,
// so a new query waits until the last one has passed the memory port and the
// evaluate pipeline (memory read, first stage, product stage).
//
// Reset clears the sequencer, the result valid, the current screen (to 0) and
// sets the screen count to 1; the table contents stay undefined until written.
// When the receiver stalls, the finished result holds in the output register;
// a following request may be accepted meanwhile, and its result waits in the
// accumulators until the output register frees up.
module screen_region_locator
    import scrl_pkg::*;
#(
    parameter int MAX_SCREENS = MAX_SCREENS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [COUNT_W-1:0]    cfg_wdata,     // screen_count
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // entry_index[2:0], pos_x[18:3], pos_y[34:19], size_w[50:35], size_h[66:51]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic [1:0]            s_axis_tuser,  // req_type[1:0]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // screen_index[2:0], overlap_area[34:3], point_found[35], left_edge[51:36],
    // right_edge[69:52], top_edge[85:70], bottom_edge[103:86]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int AW = (MAX_SCREENS > 1) ? $clog2(MAX_SCREENS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t                    state_reg;
    state_t                    state_next;
    logic [COUNT_W-1:0]        count_reg;
    logic [SEL_W-1:0]          cur_reg;
    logic [SEL_W-1:0]          cur_next;
    logic [AW-1:0]             rd_idx_reg;
    logic [AW-1:0]             rd_idx_next;
    req_e                      req_reg;
    logic signed [COORD_W-1:0] q_x_reg;
    logic signed [COORD_W-1:0] q_y_reg;
    logic [COORD_W-1:0]        q_w_reg;
    logic [COORD_W-1:0]        q_h_reg;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [OUT_DATA_W-1:0]     out_data_reg;
    logic [OUT_DATA_W-1:0]     out_data_next;

    logic                      in_xfer;
    logic                      out_free;
    logic [AW-1:0]             last_idx;
    req_e                      in_req;
    logic [ENTRY_IDX_W-1:0]    in_entry;
    logic                      mem_we;
    logic [ENTRY_W-1:0]        mem_wdata;
    logic                      mem_re;
    logic [ENTRY_W-1:0]        mem_rdata;
    logic                      issue_last;
    scan_t                     scan;
    logic [AW-1:0]             scan_idx;

    logic [AW-1:0]             best_idx;
    logic [AREA_W-1:0]         best_area;
    logic                      found;
    logic [AW-1:0]             hit_idx;
    logic signed [COORD_W-1:0] left_edge;
    logic signed [EDGE_W-1:0]  right_edge;
    logic signed [COORD_W-1:0] top_edge;
    logic signed [EDGE_W-1:0]  bottom_edge;

    logic [SEL_W-1:0]          r_sel;
    logic [AREA_W-1:0]         r_area;
    logic                      r_found;
    logic [COORD_W-1:0]        r_left;
    logic [EDGE_W-1:0]         r_right;
    logic [COORD_W-1:0]        r_top;
    logic [EDGE_W-1:0]         r_bottom;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign in_req        = req_e'(s_axis_tuser);
    assign in_entry      = s_axis_tdata[ENTRY_IDX_W-1:0];

    // Clamp the screen count to 1 .. MAX_SCREENS, expressed as the last index
    always_comb
    begin
        if (count_reg == '0)
        begin
            last_idx = '0;
        end
        else if (32'(count_reg) > MAX_SCREENS)
        begin
            last_idx = AW'(MAX_SCREENS - 1);
        end
        else
        begin
            last_idx = AW'(count_reg - COUNT_W'(1));
        end
    end

    // Table write: drop entries beyond the table
    assign mem_we    = in_xfer && (in_req == REQ_WRITE) && (32'(in_entry) < MAX_SCREENS);
    assign mem_wdata = s_axis_tdata[ENTRY_IDX_W +: ENTRY_W];
    assign mem_re    = (state_reg == ST_SCAN);
    assign issue_last = (rd_idx_reg == last_idx);

    scrl_mem #(
        .DEPTH (MAX_SCREENS),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (AW'(in_entry)),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (rd_idx_reg),
        .rdata (mem_rdata)
    );

    scrl_eval #(
        .AW (AW)
    ) u_eval (
        .clk        (clk),
        .rst_n      (rst_n),
        .issue      (mem_re),
        .issue_last (issue_last),
        .issue_idx  (rd_idx_reg),
        .rdata      (mem_rdata),
        .q_x        (q_x_reg),
        .q_y        (q_y_reg),
        .q_w        (q_w_reg),
        .q_h        (q_h_reg),
        .scan       (scan),
        .scan_idx   (scan_idx)
    );

    scrl_accum #(
        .AW (AW)
    ) u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear       (in_xfer),
        .scan        (scan),
        .scan_idx    (scan_idx),
        .best_idx    (best_idx),
        .best_area   (best_area),
        .found       (found),
        .hit_idx     (hit_idx),
        .left_edge   (left_edge),
        .right_edge  (right_edge),
        .top_edge    (top_edge),
        .bottom_edge (bottom_edge)
    );

    // Pick the result fields for the request kind; unused fields read zero
    always_comb
    begin
        r_sel    = '0;
        r_area   = '0;
        r_found  = 1'b0;
        r_left   = '0;
        r_right  = '0;
        r_top    = '0;
        r_bottom = '0;
        cur_next = cur_reg;
        unique case (req_reg)
            REQ_WRITE:
            begin
                r_sel = '0;
            end
            REQ_RECT:
            begin
                r_sel  = SEL_W'(best_idx);
                r_area = best_area;
            end
            REQ_POINT:
            begin
                if (found)
                begin
                    cur_next = SEL_W'(hit_idx);
                end
                r_sel   = cur_next;
                r_found = found;
            end
            REQ_BBOX:
            begin
                r_left   = left_edge;
                r_right  = right_edge;
                r_top    = top_edge;
                r_bottom = bottom_edge;
            end
            default:
            begin
                r_sel = '0;
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        rd_idx_next    = rd_idx_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    rd_idx_next = '0;
                    state_next  = (in_req == REQ_WRITE) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (issue_last)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    rd_idx_next = rd_idx_reg + AW'(1);
                end
            end
            ST_DRAIN:
            begin
                // last entry folds into the accumulators at this edge
                if (scan.valid && scan.last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {r_bottom, r_top, r_right, r_left, r_found, r_area, r_sel};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= COUNT_W'(1);
            cur_reg       <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
            req_reg       <= REQ_WRITE;
        end
        else
        begin
            state_reg     <= state_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
            if (in_xfer)
            begin
                req_reg <= in_req;
            end
            // current screen changes only when a point result with a hit is loaded into the output register
            if (state_reg == ST_FINISH && out_free)
            begin
                cur_reg <= cur_next;
            end
        end
    end

    // Query operands and result payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            q_x_reg <= s_axis_tdata[ENTRY_IDX_W +: COORD_W];
            q_y_reg <= s_axis_tdata[ENTRY_IDX_W + COORD_W +: COORD_W];
            q_w_reg <= s_axis_tdata[ENTRY_IDX_W + 2*COORD_W +: COORD_W];
            q_h_reg <= s_axis_tdata[ENTRY_IDX_W + 3*COORD_W +: COORD_W];
        end
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
